/* src/lrc_pkg.sv */
`default_nettype none

package lrc_pkg;

  // field widths
  localparam int DIM_W      = 16;
  localparam int COEF_W     = 32;
  localparam int COORD_W    = 32;
  localparam int HITS_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // default fraction bits of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // register reset values
  localparam logic [DIM_W-1:0] WIDTH_RST  = 16'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 16'd480;

  // rectangle sides in the order they are tested
  localparam int NUM_SIDES   = 4;
  localparam int SIDE_LEFT   = 0;
  localparam int SIDE_TOP    = 1;
  localparam int SIDE_BOTTOM = 2;
  localparam int SIDE_RIGHT  = 3;

endpackage

`default_nettype wire

/* src/lrc_ifs.sv */
`default_nettype none

// line coefficient channel
interface lrc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lrc_pkg::COEF_W-1:0]   coef_a;
  logic signed [lrc_pkg::COEF_W-1:0]   coef_b;
  logic signed [lrc_pkg::COEF_W-1:0]   coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// clipped segment channel
interface lrc_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [lrc_pkg::HITS_W-1:0]     hit_count;
  logic [lrc_pkg::COORD_W-1:0]    first_x;
  logic [lrc_pkg::COORD_W-1:0]    first_y;
  logic [lrc_pkg::COORD_W-1:0]    second_x;
  logic [lrc_pkg::COORD_W-1:0]    second_y;
  modport source (output valid, found, hit_count, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, found, hit_count, first_x, first_y, second_x, second_y,
                output ready);
endinterface

// register write channel
interface lrc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lrc_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [lrc_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

/* src/line_rectangle_clip_unit.sv */
// Line to rectangle clipper.
// A request on in_ch carries a line a*x + b*y + c = 0 (signed fixed point
// coefficients). The line is cut against the closed rectangle
// [0,image_width] x [0,image_height] in the side order left, top, bottom,
// right; out_ch returns the hit count and, when two or four sides are hit,
// the first two crossing points, else found = 0 and zero coordinates.
// The cfg channel writes image_width (index 0) and image_height (index 1);
// it is always ready. The user must write it only while no request is in
// flight; the block itself does not enforce this. The pipeline holds one
// register for the products, two for numerator setup and range check,
// DIM_W + FRAC_BITS stages of a restoring divider (one quotient bit per
// stage, four dividers side by side) and the output register.
// Throughput is one request per cycle. The pipeline advances whenever the
// output register is empty or being taken; when the receiver stalls the
// whole pipeline holds and in_ch.ready drops, nothing is lost.
// Reset (rst, synchronous) empties the pipeline and restores the
// registers to 640 x 480.
`default_nettype none

module line_rectangle_clip_unit #(
  parameter int FRAC_BITS = lrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lrc_cfg_if.sink    cfg,
  lrc_in_if.sink     in_ch,
  lrc_out_if.source  out_ch
);
  import lrc_pkg::*;

  localparam int QW = DIM_W + FRAC_BITS;       // quotient bits
  localparam int PW = COEF_W + DIM_W + 1;      // signed product width
  localparam int NW = PW + 1;                  // signed numerator width
  localparam int MW = PW - 1;                  // in-range numerator magnitude
  localparam int RW = COEF_W;                  // divider remainder width

  // configuration registers
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_WIDTH:  image_width  <= cfg.data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: products b*h and a*w
  logic                     s1_valid;
  logic signed [COEF_W-1:0] s1_a, s1_b, s1_c;
  logic signed [PW-1:0]     s1_hb, s1_wa;
  logic signed [PW-1:0]     hb_mul, wa_mul;

  always_comb begin
    hb_mul = in_ch.coef_b * $signed({1'b0, image_height});
    wa_mul = in_ch.coef_a * $signed({1'b0, image_width});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a  <= in_ch.coef_a;
      s1_b  <= in_ch.coef_b;
      s1_c  <= in_ch.coef_c;
      s1_hb <= hb_mul;
      s1_wa <= wa_mul;
    end
  end

  // stage 2: numerators, divisor magnitudes and bound products
  logic                 s2_valid;
  logic signed [NW-1:0] s2_num  [NUM_SIDES];
  logic                 s2_dneg [NUM_SIDES];
  logic [COEF_W-1:0]    s2_dmag [NUM_SIDES];
  logic [PW-1:0]        s2_lim  [NUM_SIDES];
  logic                 s2_en   [NUM_SIDES];

  logic signed [NW-1:0] c_ext;
  logic [COEF_W-1:0]    a_abs, b_abs;
  logic [PW-1:0]        hb_abs, wa_abs;

  always_comb begin
    c_ext  = NW'(s1_c);
    a_abs  = s1_a[COEF_W-1] ? (~s1_a + 1'b1) : s1_a;
    b_abs  = s1_b[COEF_W-1] ? (~s1_b + 1'b1) : s1_b;
    hb_abs = s1_hb[PW-1] ? (~s1_hb + 1'b1) : s1_hb;
    wa_abs = s1_wa[PW-1] ? (~s1_wa + 1'b1) : s1_wa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_num[SIDE_LEFT]    <= -c_ext;
      s2_num[SIDE_TOP]     <= -c_ext;
      s2_num[SIDE_BOTTOM]  <= -(NW'(s1_hb) + c_ext);
      s2_num[SIDE_RIGHT]   <= -(c_ext + NW'(s1_wa));
      s2_dneg[SIDE_LEFT]   <= s1_b[COEF_W-1];
      s2_dneg[SIDE_TOP]    <= s1_a[COEF_W-1];
      s2_dneg[SIDE_BOTTOM] <= s1_a[COEF_W-1];
      s2_dneg[SIDE_RIGHT]  <= s1_b[COEF_W-1];
      s2_dmag[SIDE_LEFT]   <= b_abs;
      s2_dmag[SIDE_TOP]    <= a_abs;
      s2_dmag[SIDE_BOTTOM] <= a_abs;
      s2_dmag[SIDE_RIGHT]  <= b_abs;
      s2_lim[SIDE_LEFT]    <= hb_abs;
      s2_lim[SIDE_TOP]     <= wa_abs;
      s2_lim[SIDE_BOTTOM]  <= wa_abs;
      s2_lim[SIDE_RIGHT]   <= hb_abs;
      s2_en[SIDE_LEFT]     <= (s1_hb != '0);
      s2_en[SIDE_TOP]      <= (s1_wa != '0);
      s2_en[SIDE_BOTTOM]   <= (s1_wa != '0);
      s2_en[SIDE_RIGHT]    <= (s1_hb != '0);
    end
  end

  // stage 3: sign fold, range check, divider load (divider stage 0)
  logic              dv_valid [QW+1];
  logic [RW-1:0]     dv_rem   [QW+1][NUM_SIDES];
  logic [QW-1:0]     dv_low   [QW+1][NUM_SIDES];
  logic [COEF_W-1:0] dv_d     [QW+1][NUM_SIDES];
  logic              dv_ok    [QW+1][NUM_SIDES];

  logic signed [NW-1:0] nfold [NUM_SIDES];

  always_comb begin
    for (int e = 0; e < NUM_SIDES; e++) begin
      nfold[e] = s2_dneg[e] ? -s2_num[e] : s2_num[e];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NUM_SIDES; e++) begin
        dv_ok[0][e]  <= s2_en[e] && !nfold[e][NW-1] && (NW'(s2_lim[e]) >= nfold[e]);
        dv_rem[0][e] <= nfold[e][MW-1:DIM_W];
        dv_low[0][e] <= QW'(nfold[e][DIM_W-1:0]) << FRAC_BITS;
        dv_d[0][e]   <= s2_dmag[e];
      end
    end
  end

  // divider stages: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW:0]   trial [NUM_SIDES];
    logic          take  [NUM_SIDES];

    always_comb begin
      for (int e = 0; e < NUM_SIDES; e++) begin
        trial[e] = {dv_rem[k][e], dv_low[k][e][QW-1]};
        take[e]  = (trial[e] >= {1'b0, dv_d[k][e]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int e = 0; e < NUM_SIDES; e++) begin
          dv_rem[k+1][e] <= take[e] ? RW'(trial[e] - {1'b0, dv_d[k][e]}) : RW'(trial[e]);
          dv_low[k+1][e] <= {dv_low[k][e][QW-2:0], take[e]};
          dv_d[k+1][e]   <= dv_d[k][e];
          dv_ok[k+1][e]  <= dv_ok[k][e];
        end
      end
    end
  end

  // hit decision and selection of the first two points
  logic [QW-1:0]      h_fix, w_fix;
  logic               hit [NUM_SIDES];
  logic [COORD_W-1:0] px  [NUM_SIDES];
  logic [COORD_W-1:0] py  [NUM_SIDES];
  logic [HITS_W-1:0]  cnt;
  logic               sel_found;
  logic [COORD_W-1:0] f_x, f_y, s_x, s_y;

  always_comb begin
    h_fix = QW'(image_height) << FRAC_BITS;
    w_fix = QW'(image_width) << FRAC_BITS;
    for (int e = 0; e < NUM_SIDES; e++) begin
      hit[e] = dv_ok[QW][e] && ((dv_low[QW][e] >> COORD_W) == '0);
    end
    hit[SIDE_BOTTOM] = hit[SIDE_BOTTOM] && ((h_fix >> COORD_W) == '0);
    hit[SIDE_RIGHT]  = hit[SIDE_RIGHT] && ((w_fix >> COORD_W) == '0);

    px[SIDE_LEFT]   = '0;
    py[SIDE_LEFT]   = COORD_W'(dv_low[QW][SIDE_LEFT]);
    px[SIDE_TOP]    = COORD_W'(dv_low[QW][SIDE_TOP]);
    py[SIDE_TOP]    = '0;
    px[SIDE_BOTTOM] = COORD_W'(dv_low[QW][SIDE_BOTTOM]);
    py[SIDE_BOTTOM] = COORD_W'(h_fix);
    px[SIDE_RIGHT]  = COORD_W'(w_fix);
    py[SIDE_RIGHT]  = COORD_W'(dv_low[QW][SIDE_RIGHT]);

    cnt = '0;
    f_x = '0;
    f_y = '0;
    s_x = '0;
    s_y = '0;
    for (int e = 0; e < NUM_SIDES; e++) begin
      if (hit[e]) begin
        if (cnt == HITS_W'(0)) begin
          f_x = px[e];
          f_y = py[e];
        end else if (cnt == HITS_W'(1)) begin
          s_x = px[e];
          s_y = py[e];
        end
        cnt = cnt + 1'b1;
      end
    end
    sel_found = (cnt == HITS_W'(2)) || (cnt == HITS_W'(4));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.found     <= sel_found;
      out_ch.hit_count <= cnt;
      out_ch.first_x   <= sel_found ? f_x : '0;
      out_ch.first_y   <= sel_found ? f_y : '0;
      out_ch.second_x  <= sel_found ? s_x : '0;
      out_ch.second_y  <= sel_found ? s_y : '0;
    end
  end

endmodule

`default_nettype wire

/* src/lrc_checker.sv */
`default_nettype none

module lrc_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          found,
  input wire logic [lrc_pkg::HITS_W-1:0]    hit_count,
  input wire logic [lrc_pkg::COORD_W-1:0]   first_x,
  input wire logic [lrc_pkg::COORD_W-1:0]   first_y,
  input wire logic [lrc_pkg::COORD_W-1:0]   second_x,
  input wire logic [lrc_pkg::COORD_W-1:0]   second_y
);
  import lrc_pkg::*;

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // found only with an even nonzero hit count
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == ((hit_count == HITS_W'(2)) || (hit_count == HITS_W'(4)))))
    else $error("found does not match hit count");

  // never more hits than sides
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_count <= HITS_W'(NUM_SIDES)))
    else $error("hit count out of range");

  // no points reported when not found
  a_zero_points: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |->
      (first_x == '0 && first_y == '0 && second_x == '0 && second_y == '0))
    else $error("points reported without a segment");

  // stalled request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(found) && $stable(hit_count) && $stable(first_x)
       && $stable(first_y) && $stable(second_x) && $stable(second_y)))
    else $error("stalled request changed");

endmodule

bind line_rectangle_clip_unit lrc_checker u_lrc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .found     (out_ch.found),
  .hit_count (out_ch.hit_count),
  .first_x   (out_ch.first_x),
  .first_y   (out_ch.first_y),
  .second_x  (out_ch.second_x),
  .second_y  (out_ch.second_y)
);

`default_nettype wire

/* tb/lrc_clip_checker.sv */
`default_nettype none

module lrc_clip_checker (
  input  wire logic clk,
  input  wire logic rst,
  lrc_cfg_if.sink   cfg_mon,
  lrc_in_if.sink    in_mon,
  lrc_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending,
  output int        accepted_lines,
  output int        segments_found
);
  import lrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                found;
    logic [HITS_W-1:0]   hit_count;
    logic [COORD_W-1:0]  first_x;
    logic [COORD_W-1:0]  first_y;
    logic [COORD_W-1:0]  second_x;
    logic [COORD_W-1:0]  second_y;
  } segment_t;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned COORD_LIM = 64'hFFFF_FFFF;

  logic [DIM_W-1:0] width_q, height_q;
  segment_t         expected_segs[$];

  // exact bound test 0 <= n/d <= lim, then floor quotient in fixed point
  function automatic bit side_ratio(input longint n, input longint d, input longint lim,
                                    output longint unsigned q);
    longint unsigned un, ud, qi, rm, v;
    q = 0;
    if (d == 0) return 0;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n < 0) return 0;
    if (n > lim * d) return 0;
    un = n;
    ud = d;
    qi = un / ud;
    rm = un % ud;
    v = (qi << FB) + ((rm << FB) / ud);
    if (v > COORD_LIM) return 0;
    q = v;
    return 1;
  endfunction

  function automatic segment_t clip_line(input logic signed [COEF_W-1:0] ca,
                                         input logic signed [COEF_W-1:0] cb,
                                         input logic signed [COEF_W-1:0] cc);
    longint a, b, c, w, h;
    longint unsigned px[4], py[4], q;
    int nh;
    segment_t s;
    a = ca; b = cb; c = cc;
    w = width_q; h = height_q;
    nh = 0;
    s = '0;
    // left side
    if (h != 0 && b != 0 && side_ratio(-c, b, h, q)) begin
      px[nh] = 0; py[nh] = q; nh++;
    end
    // top side
    if (w != 0 && a != 0 && side_ratio(-c, a, w, q)) begin
      px[nh] = q; py[nh] = 0; nh++;
    end
    // bottom side
    if (w != 0 && a != 0 && side_ratio(-(b * h + c), a, w, q) &&
        ((h << FB) <= COORD_LIM)) begin
      px[nh] = q; py[nh] = h << FB; nh++;
    end
    // right side
    if (h != 0 && b != 0 && side_ratio(-(c + a * w), b, h, q) &&
        ((w << FB) <= COORD_LIM)) begin
      px[nh] = w << FB; py[nh] = q; nh++;
    end
    s.hit_count = nh[HITS_W-1:0];
    if (nh == 2 || nh == 4) begin
      s.found = 1'b1;
      s.first_x = px[0][31:0];
      s.first_y = py[0][31:0];
      s.second_x = px[1][31:0];
      s.second_y = py[1][31:0];
    end
    return s;
  endfunction

  assign pending = expected_segs.size();

  always @(posedge clk) begin
    segment_t e;
    if (rst) begin
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      expected_segs.delete();
      fail_count <= 0;
      accepted_lines <= 0;
      segments_found <= 0;
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.reg_index == REG_WIDTH) width_q <= cfg_mon.data;
        else if (cfg_mon.reg_index == REG_HEIGHT) height_q <= cfg_mon.data;
      end
      // predict each accepted request
      if (in_mon.valid && in_mon.ready) begin
        expected_segs.insert(expected_segs.size(),
                             clip_line(in_mon.coef_a, in_mon.coef_b, in_mon.coef_c));
        accepted_lines <= accepted_lines + 1;
      end
      // compare each returned segment
      if (out_mon.valid && out_mon.ready) begin
        if (expected_segs.size() == 0) begin
          $error("segment returned with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_segs.pop_front();
          if (e.found) segments_found <= segments_found + 1;
          if (e.found !== out_mon.found || e.hit_count !== out_mon.hit_count ||
              e.first_x !== out_mon.first_x || e.first_y !== out_mon.first_y ||
              e.second_x !== out_mon.second_x || e.second_y !== out_mon.second_y) begin
            fail_count <= fail_count + 1;
            if (e.found !== out_mon.found)
              $error("found: expected %0d actual %0d", e.found, out_mon.found);
            if (e.hit_count !== out_mon.hit_count)
              $error("hit_count: expected %0d actual %0d", e.hit_count, out_mon.hit_count);
            if (e.first_x !== out_mon.first_x)
              $error("first_x: expected %h actual %h", e.first_x, out_mon.first_x);
            if (e.first_y !== out_mon.first_y)
              $error("first_y: expected %h actual %h", e.first_y, out_mon.first_y);
            if (e.second_x !== out_mon.second_x)
              $error("second_x: expected %h actual %h", e.second_x, out_mon.second_x);
            if (e.second_y !== out_mon.second_y)
              $error("second_y: expected %h actual %h", e.second_y, out_mon.second_y);
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

/* tb/tb_line_rectangle_clip_unit.sv */
`default_nettype none

module tb_line_rectangle_clip_unit;
  import lrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;

  // index past the defined registers, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending, accepted_lines, segments_found;
  int   idle_cycles = 0;
  bit   calm = 1'b0;
  bit   hold_off = 1'b0;

  lrc_cfg_if cfg();
  lrc_in_if  in_ch();
  lrc_out_if out_ch();

  line_rectangle_clip_unit dut (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );

  lrc_clip_checker checker_i (
    .clk(clk), .rst(rst), .cfg_mon(cfg), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending(pending),
    .accepted_lines(accepted_lines), .segments_found(segments_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.reg_index = REG_WIDTH;
    cfg.data = '0;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, a calm stretch, and one long hold-off
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // watchdog on cycles without any accepted request or segment
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_line_rectangle_clip_unit failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one line request, with a random gap before it unless calm
  task automatic send_line(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.coef_a <= a;
    in_ch.coef_b <= b;
    in_ch.coef_c <= c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // lines through two random points of the rectangle, integer-scaled to fit
  task automatic send_chord(input int unsigned w, input int unsigned h);
    longint x0, y0, x1, y1, a, b, c, s;
    x0 = $urandom_range(w); y0 = $urandom_range(h);
    x1 = $urandom_range(w); y1 = $urandom_range(h);
    a = y1 - y0; b = x0 - x1;
    c = -(a * x0 + b * y0);
    s = $urandom_range(3);
    a = a << s; b = b << s; c = c << s;
    if (c > 64'sh7FFFFFFF || c < -64'sh80000000) begin
      a = a >>> 8; b = b >>> 8; c = c >>> 8;
    end
    if (c > 64'sh7FFFFFFF || c < -64'sh80000000) c = $urandom;
    send_line(a[31:0], b[31:0], c[31:0]);
  endtask

  task automatic random_phase(input int n, input int unsigned w, input int unsigned h);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1: send_line($urandom, $urandom, $urandom);
        2: send_line({{16{1'b0}}, 16'($urandom)} << $urandom_range(16),
                     $urandom_range(3) == 0 ? 32'd0 : $urandom, $urandom);
        3: send_line(32'd0, $urandom_range(1, 255), -$urandom_range(0, h * 300));
        default: send_chord(w, h);
      endcase
    end
  endtask

  initial begin
    int unsigned dims[5][2];
    int p;
    dims = '{'{640, 480}, '{65535, 65535}, '{1, 1}, '{1, 65535}, '{37, 1000}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, axis-parallel lines, corners, zero terms
    send_line(32'h0, 32'h0, 32'h0);
    send_line(32'h0, 32'h0, 32'h1);
    send_line(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_line(32'h80000000, 32'h80000000, 32'h80000000);
    send_line(32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_line(32'hFFFFFFFF, 32'h1, 32'h0);
    send_line(32'd1, 32'd0, -32'd320);
    send_line(32'd0, 32'd1, -32'd240);
    send_line(32'd1, 32'd0, 32'd0);
    send_line(32'd0, 32'd1, -32'd480);
    send_line(32'd480, 32'd640, -32'd307200);
    send_line(32'd480, -32'd640, 32'd0);
    send_line(32'd1, 32'd1, 32'd0);
    send_line(32'd1, 32'd1, -32'd1120);
    send_line(32'd3, 32'd7, -32'd1000);
    send_line(32'd1, 32'd1, -32'd100);
    send_line(32'd65536, 32'd65536, -32'd65536);
    send_line(32'd1, 32'd2, -32'd2000);
    send_line(32'd1, 32'd0, -32'd641);
    send_line(32'h7FFFFFFF, 32'h1, 32'h80000000);
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(80, 640, 480);
    join
    wait_idle();

    // settings sweep, one calm stretch
    for (p = 0; p < 5; p++) begin
      write_reg(REG_WIDTH, 16'(dims[p][0]));
      write_reg(REG_HEIGHT, 16'(dims[p][1]));
      write_reg(REG_UNUSED, 16'($urandom));
      calm = (p == 1);
      random_phase(p == 0 ? 240 : 140, dims[p][0], dims[p][1]);
      calm = 1'b0;
      wait_idle();
    end
    // zero-sized rectangle and width-only
    write_reg(REG_WIDTH, 16'd0);
    random_phase(20, 0, 480);
    wait_idle();
    write_reg(REG_HEIGHT, 16'd0);
    random_phase(20, 0, 0);
    wait_idle();

    $display("covered %0d lines over 7 rectangle settings, %0d clipped segments",
             accepted_lines, segments_found);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_line_rectangle_clip_unit passed");
    end else begin
      $display("tb_line_rectangle_clip_unit failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* sim.f */
src/lrc_pkg.sv
src/lrc_ifs.sv
src/line_rectangle_clip_unit.sv
src/lrc_checker.sv
tb/lrc_clip_checker.sv
tb/tb_line_rectangle_clip_unit.sv
